// ----- sv/aiod_pkg.sv -----
// Shared types, address constants and the protection byte table for the
// arcade I/O decoder. No dependencies.
`default_nettype none

package aiod_pkg;

	localparam int TILE_AW = 10;
	localparam int TILE_DEPTH = 1 << TILE_AW;

	localparam logic [15:0] ADDR_TILE_BASE = 16'h8000;
	localparam logic [15:0] ADDR_TILE_MASK = 16'hFC00;
	localparam logic [15:0] ADDR_BANK      = 16'h8400;
	localparam logic [15:0] ADDR_SND_DATA  = 16'h8C00;
	localparam logic [15:0] ADDR_SND_SEL   = 16'h8C01;
	localparam logic [15:0] ADDR_DIP_IRQ   = 16'h8D00;
	localparam logic [15:0] ADDR_PORT_A    = 16'h8D40;
	localparam logic [15:0] ADDR_PORT_B    = 16'h8D80;
	localparam logic [15:0] ADDR_PORT_C    = 16'h8DC0;
	localparam logic [15:0] ADDR_FLIP      = 16'h8DC0;
	localparam logic [7:0]  GUARD_PAGE     = 8'h08;
	localparam logic [15:0] GUARD_PC       = 16'h53D7;

	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_FETCH = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		SND_NONE   = 2'd0,
		SND_DATA   = 2'd1,
		SND_SELECT = 2'd2
	} sound_t;

	typedef struct packed {
		logic [7:0]  read_data;
		sound_t      sound_access;
		logic [7:0]  sound_value;
		logic        irq_clear;
		logic        flip_next;
		logic        bank_we;
		logic        ram_we;
		logic [15:0] ram_wdata;
		logic        fetch;
	} dec_t;

	function automatic logic [7:0] guard_byte(input logic [7:0] offset,
		input logic [15:0] pc);
		logic [7:0] b;
		case (offset)
			8'h08: b = 8'hB0;
			8'h26: b = (pc == GUARD_PC) ? 8'h06 : 8'hC6;
			8'h86: b = 8'h91;
			8'hAE: b = 8'h32;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- sv/aiod_tile_ram.sv -----
// Tile RAM: 1024 x 16 synchronous memory, one write and one read port,
// registered read data, with a clearing sweep after reset. Uses aiod_pkg.
`default_nettype none

module aiod_tile_ram (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [aiod_pkg::TILE_AW-1:0] wr_addr,
	input  wire logic [15:0]                wr_data,
	input  wire logic                       rd_en,
	input  wire logic [aiod_pkg::TILE_AW-1:0] rd_addr,
	output logic      [15:0]                rd_data,
	output logic                            busy
);

	logic [15:0] mem [aiod_pkg::TILE_DEPTH];
	logic [aiod_pkg::TILE_AW-1:0] clr_addr_q;
	logic clr_busy_q;
	logic                         we;
	logic [aiod_pkg::TILE_AW-1:0] waddr;
	logic [15:0]                  wdata;

	// sweep zeros over every entry, then hand the port to the user
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q)
				clr_busy_q <= 1'b0;
		end
	end

	always_comb begin
		we    = clr_busy_q | wr_en;
		waddr = clr_busy_q ? clr_addr_q : wr_addr;
		wdata = clr_busy_q ? 16'h0000 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	assign busy = clr_busy_q;

endmodule

`default_nettype wire

// ----- sv/aiod_decode.sv -----
// Address decode for one bus word: read data, register and RAM writes,
// sound pass-through and interrupt acknowledge. Uses aiod_pkg.
`default_nettype none

module aiod_decode (
	input  wire logic [1:0]  func,
	input  wire logic [15:0] bus_address,
	input  wire logic [7:0]  write_data,
	input  wire logic [15:0] cpu_pc,
	input  wire logic [7:0]  port_a,
	input  wire logic [7:0]  port_b,
	input  wire logic [7:0]  port_c,
	input  wire logic [7:0]  dip,
	input  wire logic [7:0]  bank_hi,
	input  wire logic        flip,
	output aiod_pkg::dec_t   dec
);

	logic tile_win;
	logic guard_win;

	assign tile_win  = (bus_address & aiod_pkg::ADDR_TILE_MASK) == aiod_pkg::ADDR_TILE_BASE;
	assign guard_win = bus_address[15:8] == aiod_pkg::GUARD_PAGE;

	always_comb begin
		dec = '0;
		dec.sound_access = aiod_pkg::SND_NONE;
		dec.flip_next = flip;
		// bank low byte is always zero, so the sum is a concatenation
		dec.ram_wdata = {bank_hi, write_data};
		case (aiod_pkg::func_t'(func))
			aiod_pkg::FUNC_READ: begin
				if (guard_win)
					dec.read_data = aiod_pkg::guard_byte(bus_address[7:0], cpu_pc);
				else if (!tile_win) begin
					case (bus_address)
						aiod_pkg::ADDR_DIP_IRQ: dec.read_data = dip;
						aiod_pkg::ADDR_PORT_A:  dec.read_data = port_a;
						aiod_pkg::ADDR_PORT_B:  dec.read_data = port_b;
						aiod_pkg::ADDR_PORT_C:  dec.read_data = port_c;
						default:                dec.read_data = 8'h00;
					endcase
				end
			end
			aiod_pkg::FUNC_WRITE: begin
				if (tile_win)
					dec.ram_we = 1'b1;
				else begin
					case (bus_address)
						aiod_pkg::ADDR_BANK: dec.bank_we = 1'b1;
						aiod_pkg::ADDR_SND_DATA: begin
							dec.sound_access = aiod_pkg::SND_DATA;
							dec.sound_value  = write_data;
						end
						aiod_pkg::ADDR_SND_SEL: begin
							dec.sound_access = aiod_pkg::SND_SELECT;
							dec.sound_value  = write_data;
						end
						aiod_pkg::ADDR_DIP_IRQ: dec.irq_clear = 1'b1;
						aiod_pkg::ADDR_FLIP:    dec.flip_next = write_data[0];
						default: ;
					endcase
				end
			end
			aiod_pkg::FUNC_FETCH: dec.fetch = 1'b1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/arcade_io_decoder_with_tile_ram_core.sv -----
// Top level of the arcade I/O decoder: stream ports, bank, flip and DIP
// registers, output stage. Uses aiod_pkg, aiod_decode and aiod_tile_ram.
//
// One word in, one word out. A word is taken every cycle the output side
// keeps up; its result shows in the next cycle from the output register, whose
// tile_code comes straight from the tile RAM's registered read port. CPU
// writes land in the tile RAM in the cycle they are taken, so a fetch right
// behind a write sees the new entry. After reset the tile RAM is cleared one
// entry per cycle, and s_tready stays low until that is done; the DIP
// register can be written at any time.
`default_nettype none

module arcade_io_decoder_with_tile_ram_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,    // dip_switch_b
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// bus_address[15:0], write_data[23:16], cpu_pc[39:24], port_a[47:40],
	// port_b[55:48], port_c[63:56], tile_index[73:64], zero[79:74]
	input  wire logic [79:0] s_tdata,
	input  wire logic [1:0]  s_tuser,      // func[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_data[7:0], tile_code[23:8], sound_access[25:24],
	// sound_value[33:26], irq_clear[34], flip_screen[35], zero[39:36]
	output logic      [39:0] m_tdata
);

	aiod_pkg::dec_t dec;
	logic        accept;
	logic        ram_busy;
	logic [15:0] ram_rdata;

	logic [7:0] dip_q;
	logic [7:0] bank_q;
	logic       flip_q;

	logic       valid_s1;
	logic [7:0] read_data_s1;
	logic [1:0] sound_access_s1;
	logic [7:0] sound_value_s1;
	logic       irq_clear_s1;
	logic       flip_s1;
	logic       fetch_s1;

	aiod_decode u_decode (
		.func        (s_tuser),
		.bus_address (s_tdata[15:0]),
		.write_data  (s_tdata[23:16]),
		.cpu_pc      (s_tdata[39:24]),
		.port_a      (s_tdata[47:40]),
		.port_b      (s_tdata[55:48]),
		.port_c      (s_tdata[63:56]),
		.dip         (dip_q),
		.bank_hi     (bank_q),
		.flip        (flip_q),
		.dec         (dec)
	);

	aiod_tile_ram u_tile_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept & dec.ram_we),
		.wr_addr (s_tdata[aiod_pkg::TILE_AW-1:0]),
		.wr_data (dec.ram_wdata),
		.rd_en   (accept & dec.fetch),
		.rd_addr (s_tdata[64 +: aiod_pkg::TILE_AW]),
		.rd_data (ram_rdata),
		.busy    (ram_busy)
	);

	assign s_tready = !ram_busy && (!valid_s1 || m_tready);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dip_q <= 8'h00;
		else if (cfg_we)
			dip_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 8'h00;
			flip_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				flip_q   <= dec.flip_next;
				if (dec.bank_we)
					bank_q <= s_tdata[23:16];
			end else if (m_tready)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_s1    <= dec.read_data;
			sound_access_s1 <= dec.sound_access;
			sound_value_s1  <= dec.sound_value;
			irq_clear_s1    <= dec.irq_clear;
			flip_s1         <= dec.flip_next;
			fetch_s1        <= dec.fetch;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tdata  = {4'h0, flip_s1, irq_clear_s1, sound_value_s1, sound_access_s1,
		fetch_s1 ? ram_rdata : 16'h0000, read_data_s1};

endmodule

`default_nettype wire

// ----- sv/aiod_checker.sv -----
// Port-level checks for the arcade I/O decoder, bound to the top level.
// Depends on arcade_io_decoder_with_tile_ram_core ports only.
`default_nettype none

module aiod_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_we,
	input wire logic [7:0]  cfg_wdata,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [79:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_irq_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> m_tdata[33:0] == 34'd0)
		else $error("irq acknowledge with other results");

	a_sound_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25:24] != 2'b11)
		else $error("bad sound access code");

	a_clear_pass: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !s_tready)
		else $error("input taken during tile RAM clear");

	a_flip: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == 2'd1 && s_tdata[15:0] == 16'h8DC0
		|=> m_tvalid && m_tdata[35] == $past(s_tdata[16]))
		else $error("flip write not reflected");

endmodule

bind arcade_io_decoder_with_tile_ram_core aiod_checker u_aiod_checker (.*);

`default_nettype wire
